FILE: rtl/target_frame_parser_with_timeout_top_assert.svh
// ----------------------------------------------------------------------------
// Target frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TARGET_FRAME_PARSER_WITH_TIMEOUT_TOP_ASSERT_SVH
`define TARGET_FRAME_PARSER_WITH_TIMEOUT_TOP_ASSERT_SVH

// A plain property that must hold at every clock edge outside reset.
`define TFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by a consequence on the next edge.
`define TFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// Target frame parser package
// Frame constants, parser positions and the result types shared by all modules.
// ----------------------------------------------------------------------------
package tfp_pkg;

    // Frame delimiters.
    localparam logic [7:0] FRAME_HEAD = 8'hAA;
    localparam logic [7:0] FRAME_TAIL = 8'h55;

    // Parser positions: waiting for head, data slots, checksum and tail.
    localparam int         POS_W          = 4;
    localparam logic [3:0] POS_WAIT       = 4'd0;
    localparam logic [3:0] POS_FIRST      = 4'd1;
    localparam logic [3:0] POS_DATA_LAST  = 4'd11;
    localparam logic [3:0] POS_CHECKSUM   = 4'd12;
    localparam logic [3:0] POS_TAIL       = 4'd13;

    // Pending bytes: the find byte and ten data bytes.
    localparam int PEND_N     = 11;
    localparam int PEND_IDX_W = 4;

    // Link age counter.
    localparam int              AGE_W         = 17;
    localparam logic [AGE_W-1:0] AGE_MAX      = 17'h1FFFF;
    localparam logic [15:0]     TIMEOUT_RESET = 16'd500;

    // Result beat layout on the master side.
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_PAD_W   = 6;

    typedef logic [PEND_N-1:0][7:0] pend_t;

    // Published target record.
    typedef struct packed {
        logic               found;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic        [15:0] range_cm;
    } pub_t;

    // Parser event toward the timer and output stage.
    typedef struct packed {
        logic accepted;
        pub_t pub;
    } frame_evt_t;

    // One complete result beat.
    typedef struct packed {
        logic       frame_accepted;
        pub_t       pub;
        logic       link_online;
    } result_t;

    // Build the published record from the pending bytes (big-endian fields).
    function automatic pub_t build_pub(input pend_t pend);
        pub_t p;
        p.found       = (pend[0] != 8'd0);
        p.center_x    = {pend[1], pend[2]};
        p.center_y    = {pend[3], pend[4]};
        p.box_width   = {pend[5], pend[6]};
        p.box_height  = {pend[7], pend[8]};
        p.range_cm    = {pend[9], pend[10]};
        return p;
    endfunction

endpackage

FILE: rtl/tfp_parser.sv
// ----------------------------------------------------------------------------
// Target frame byte parser
// Walks the 14-byte frame, checks tail and checksum and holds the published
// target record.
// ----------------------------------------------------------------------------
module tfp_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [7:0]        rx_byte,
    output tfp_pkg::frame_evt_t evt
);
    import tfp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       chk_reg, chk_next;
    pend_t            pend_reg, pend_next;
    pub_t             pub_reg, pub_next;
    logic             accepted;
    logic [PEND_IDX_W-1:0] slot;

    assign slot = PEND_IDX_W'(pos_reg - POS_FIRST);

    // Next-state logic for one received byte.
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        chk_next  = chk_reg;
        pend_next = pend_reg;
        pub_next  = pub_reg;
        accepted  = 1'b0;
        if (byte_en)
        begin
            case (pos_reg)
                POS_WAIT:
                begin
                    if (rx_byte == FRAME_HEAD)
                    begin
                        sum_next = rx_byte;
                        pos_next = POS_FIRST;
                    end
                end
                POS_CHECKSUM:
                begin
                    chk_next = rx_byte;
                    pos_next = POS_TAIL;
                end
                POS_TAIL:
                begin
                    if ((rx_byte == FRAME_TAIL) && (chk_reg == sum_reg))
                    begin
                        accepted = 1'b1;
                        pub_next = build_pub(pend_reg);
                    end
                    pos_next = POS_WAIT;
                end
                default:
                begin
                    if (pos_reg <= POS_DATA_LAST)
                    begin
                        pend_next[slot] = rx_byte;
                        sum_next        = sum_reg + rx_byte;
                        pos_next        = pos_reg + POS_FIRST;
                    end
                    else
                    begin
                        pos_next = POS_WAIT;
                    end
                end
            endcase
        end
    end

    // Control state and published record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_WAIT;
            sum_reg <= 8'd0;
            chk_reg <= 8'd0;
            pub_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            chk_reg <= chk_next;
            pub_reg <= pub_next;
        end
    end

    // Pending data bytes are always written before they are published.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign evt.accepted = accepted;
    assign evt.pub      = pub_next;

    `include "target_frame_parser_with_timeout_top_assert.svh"

    `TFP_ASSERT(a_pos_range, pos_reg <= POS_TAIL, "parser position beyond tail slot")
    `TFP_ASSERT(a_acc_at_tail, !accepted || (pos_reg == POS_TAIL),
                "frame accepted outside tail slot")
    `TFP_ASSERT_NEXT(a_acc_rewait, accepted, pos_reg == POS_WAIT,
                     "parser not waiting for head after accepted frame")

endmodule

FILE: rtl/tfp_link_timer.sv
// ----------------------------------------------------------------------------
// Link timeout tracker
// Saturating age count since the last accepted frame and the online flag,
// with the timeout register and its write channel.
// ----------------------------------------------------------------------------
module tfp_link_timer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_en,
    input  logic        frame_acc,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        online
);
    import tfp_pkg::*;

    logic [AGE_W-1:0] age_reg, age_next;
    logic             seen_reg, seen_next;
    logic [15:0]      timeout_reg;

    assign cfg_ready = 1'b1;

    // Age and seen-flag update; a tick and a frame never share a beat.
    always_comb
    begin
        age_next  = age_reg;
        seen_next = seen_reg;
        if (frame_acc)
        begin
            age_next  = '0;
            seen_next = 1'b1;
        end
        else if (tick_en && (age_reg != AGE_MAX))
        begin
            age_next = age_reg + AGE_W'(1);
        end
    end

    // Online after this beat's update.
    assign online = seen_next && (age_next <= {1'b0, timeout_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg     <= '0;
            seen_reg    <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            age_reg  <= age_next;
            seen_reg <= seen_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    `include "target_frame_parser_with_timeout_top_assert.svh"

    `TFP_ASSERT_NEXT(a_age_clear, frame_acc, (age_reg == '0) && seen_reg,
                     "age not cleared after accepted frame")

endmodule

FILE: rtl/tfp_out_buf.sv
// ----------------------------------------------------------------------------
// Result output buffer
// Two-entry register buffer that keeps input acceptance going while a result
// beat waits on the master side.
// ----------------------------------------------------------------------------
module tfp_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tfp_pkg::result_t push_data,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output tfp_pkg::result_t out_data
);
    import tfp_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign space     = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;
    assign pop       = out_valid && out_ready;

    // Entry movement for push, pop or both.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    head_next = push_data;
                else
                    tail_next = push_data;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = tail_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    `include "target_frame_parser_with_timeout_top_assert.svh"

    `TFP_ASSERT(a_cnt_range, cnt_reg <= 2'd2, "output buffer count overflow")
    `TFP_ASSERT_NEXT(a_fill, push && !pop && (cnt_reg == 2'd1), cnt_reg == 2'd2,
                     "output buffer did not take second beat")

endmodule

FILE: rtl/target_frame_parser_with_timeout_top.sv
// ----------------------------------------------------------------------------
// Target frame parser with link timeout
// Serial target-frame parser with checksum check and link-online timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one beat is a received byte (tuser = 0, byte in tdata) or a
//   one-millisecond tick (tuser = 1, tdata ignored).
//   Master side: exactly one result beat per input beat, in order. tuser
//   flags a beat whose byte completed a valid frame; tdata carries the
//   published target record and the link-online flag.
//   Config channel: cfg_data sets the online timeout in ticks; write it only
//   while the block is idle. cfg_ready is always high.
//   The result of an accepted beat is formed combinationally and registered
//   in the output buffer, shown in the following cycle when the buffer was
//   empty. Throughput is one beat per cycle while the buffer has space.
//   Reset: the parser waits for a head byte, the published record is zero,
//   the link is offline and the timeout is 500 ticks.
//   Stall: a two-entry output buffer holds results while m_axis_tready is
//   low; s_axis_tready drops only when both entries are full.
// ----------------------------------------------------------------------------
module target_frame_parser_with_timeout_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic        s_axis_tuser,  // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [tfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] target_found, [16:1] center_x, [32:17] center_y, [48:33] box_width,
    // [64:49] box_height, [80:65] range_cm, [81] link_online, [87:82] zero
    output logic        m_axis_tuser,  // [0] frame_accepted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import tfp_pkg::*;

    logic       in_beat;
    logic       byte_en;
    logic       tick_en;
    logic       online;
    frame_evt_t evt;
    result_t    res;
    result_t    out_res;

    // Input beat decode.
    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign byte_en = in_beat && !s_axis_tuser;
    assign tick_en = in_beat && s_axis_tuser;

    tfp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (s_axis_tdata),
        .evt     (evt)
    );

    tfp_link_timer u_timer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (tick_en),
        .frame_acc (evt.accepted),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .online    (online)
    );

    // Assemble the result beat.
    assign res.frame_accepted = evt.accepted;
    assign res.pub            = evt.pub;
    assign res.link_online    = online;

    tfp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_beat),
        .push_data (res),
        .space     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    // Pack the master-side beat, first field in the lowest bits.
    assign m_axis_tuser = out_res.frame_accepted;
    assign m_axis_tdata = {OUT_PAD_W'(0),
                           out_res.link_online,
                           out_res.pub.range_cm,
                           out_res.pub.box_height,
                           out_res.pub.box_width,
                           out_res.pub.center_y,
                           out_res.pub.center_x,
                           out_res.pub.found};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Target frame parser testbench
// Drives byte and tick beats into the parser and compares every result beat
// against a cycle-free prediction of the frame parser, publisher and link age
// counter. Covers reset state, field extremes, broken frames, timeout edges
// and random framed traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import tfp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // Ways a generated frame can be sent.
    typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_CUT} frame_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic                   s_axis_tuser = 1'b0;   // [0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] target_found, [16:1] center_x, [32:17] center_y, [48:33] box_width,
    // [64:49] box_height, [80:65] range_cm, [81] link_online, [87:82] zero
    logic                   m_axis_tuser;          // [0] frame_accepted
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [15:0]            cfg_data = 16'd0;

    // Predicted parser, publisher and link state.
    logic [3:0]       frame_pos = POS_WAIT;
    logic [7:0]       frame_sum = 8'd0;
    logic [7:0]       frame_chk = 8'd0;
    logic [7:0]       frame_bytes [PEND_N];
    pub_t             shown = '0;
    logic             link_seen = 1'b0;
    logic [AGE_W-1:0] link_age = '0;
    logic [15:0]      link_timeout = TIMEOUT_RESET;

    result_t predicted_beats [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      idle_odds = 4;
    int      hold_left = 0;

    target_frame_parser_with_timeout_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Advance the predicted state by one input beat and return its result.
    function automatic result_t parse_and_age(input logic tick, input logic [7:0] b);
        result_t r;
        logic    hit;
        hit = 1'b0;
        if (tick)
        begin
            if (link_age != AGE_MAX)
                link_age = link_age + 1'b1;
        end
        else
        begin
            case (frame_pos)
                POS_WAIT:
                begin
                    if (b == FRAME_HEAD)
                    begin
                        frame_sum = b;
                        frame_pos = POS_FIRST;
                    end
                end
                POS_CHECKSUM:
                begin
                    frame_chk = b;
                    frame_pos = POS_TAIL;
                end
                POS_TAIL:
                begin
                    if (b == FRAME_TAIL && frame_chk == frame_sum)
                    begin
                        shown.found       = (frame_bytes[0] != 8'd0);
                        shown.center_x    = {frame_bytes[1], frame_bytes[2]};
                        shown.center_y    = {frame_bytes[3], frame_bytes[4]};
                        shown.box_width   = {frame_bytes[5], frame_bytes[6]};
                        shown.box_height  = {frame_bytes[7], frame_bytes[8]};
                        shown.range_cm    = {frame_bytes[9], frame_bytes[10]};
                        link_seen = 1'b1;
                        link_age  = '0;
                        hit = 1'b1;
                    end
                    frame_pos = POS_WAIT;
                end
                default:
                begin
                    // Data slots store the byte; the unused positions fall back to waiting.
                    if (frame_pos >= POS_FIRST && frame_pos <= POS_DATA_LAST)
                    begin
                        frame_bytes[frame_pos - 1] = b;
                        frame_sum = frame_sum + b;
                        frame_pos = frame_pos + 1'b1;
                    end
                    else
                        frame_pos = POS_WAIT;
                end
            endcase
        end
        r.frame_accepted = hit;
        r.pub            = shown;
        r.link_online    = link_seen && (link_age <= {1'b0, link_timeout});
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    function automatic void check_result(input result_t want, input logic accepted,
                                         input logic [OUT_TDATA_W-1:0] data);
        check_field("frame_accepted", 16'(want.frame_accepted), 16'(accepted));
        check_field("target_found", 16'(want.pub.found), 16'(data[0]));
        check_field("center_x", want.pub.center_x, data[16:1]);
        check_field("center_y", want.pub.center_y, data[32:17]);
        check_field("box_width", want.pub.box_width, data[48:33]);
        check_field("box_height", want.pub.box_height, data[64:49]);
        check_field("range_cm", want.pub.range_cm, data[80:65]);
        check_field("link_online", 16'(want.link_online), 16'(data[81]));
        check_field("padding", 16'd0, 16'(data[87:82]));
    endfunction

    // Compare each accepted result beat, then predict each accepted input beat.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else
                    check_result(predicted_beats.pop_front(), m_axis_tuser, m_axis_tdata);
            end
            if (cfg_valid && cfg_ready)
                link_timeout = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predicted_beats.push_back(parse_and_age(s_axis_tuser, s_axis_tdata));
        end
    end

    // Receiver backpressure in short random bursts.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            hold_left     <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one beat, with an occasional gap first; returns at the accepting edge.
    task automatic push_beat(input logic tick, input logic [7:0] b);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick;
        s_axis_tdata  <= tick ? 8'($urandom) : b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted beat has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        // Step the clock first so the last accepted beat is already predicted.
        @(posedge clk);
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one frame; a tick goes before byte tick_slot and at random with tick_odds.
    task automatic send_frame(input frame_kind_t kind, input logic [7:0] find,
                              input logic [15:0] vals [5], input int tick_slot,
                              input int tick_odds);
        logic [7:0] bytes [14];
        logic [7:0] sum;
        int         last;
        bytes[0] = FRAME_HEAD;
        bytes[1] = find;
        for (int k = 0; k < 5; k++)
        begin
            bytes[2 + 2 * k] = vals[k][15:8];
            bytes[3 + 2 * k] = vals[k][7:0];
        end
        sum = 8'd0;
        for (int k = 0; k < 12; k++)
            sum = sum + bytes[k];
        bytes[12] = sum;
        bytes[13] = FRAME_TAIL;
        last = 13;
        case (kind)
            FRAME_BAD_SUM:  bytes[12] = sum ^ 8'($urandom_range(1, 255));
            FRAME_BAD_TAIL:
            begin
                bytes[13] = 8'($urandom_range(0, 254));
                if (bytes[13] == FRAME_TAIL)
                    bytes[13] = 8'hFF;
            end
            FRAME_CUT:      last = $urandom_range(1, 12);
            default:        ;
        endcase
        for (int k = 0; k <= last; k++)
        begin
            if (k == tick_slot || (tick_odds != 0 && $urandom_range(1, tick_odds) == 1))
                push_beat(1'b1, 8'd0);
            push_beat(1'b0, bytes[k]);
        end
    endtask

    // Field values lean toward the signed and unsigned extremes.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Ticks and stray bytes before any frame leave everything zero and offline.
    task automatic test_idle_after_reset();
        push_beat(1'b1, 8'd0);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, FRAME_TAIL);
    endtask

    // A good frame at the field extremes with a tick inside, then a bad checksum.
    task automatic test_frame_extremes();
        logic [15:0] vals [5];
        vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF};
        send_frame(FRAME_GOOD, 8'h01, vals, 6, 0);
        vals = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001};
        send_frame(FRAME_BAD_SUM, 8'hFF, vals, -1, 0);
    endtask

    // With the reset timeout the link drops on the tick past 500.
    task automatic test_default_timeout();
        int left;
        int burst;
        left = 505;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            repeat (burst) push_beat(1'b1, 8'd0);
            left -= burst;
        end
    endtask

    // Timeout register at zero, at its maximum, and moved across the current age.
    task automatic test_timeout_edges();
        logic [15:0] vals [5];
        for (int k = 0; k < 5; k++)
            vals[k] = pick_word();
        write_timeout(16'd0);
        send_frame(FRAME_GOOD, 8'($urandom), vals, -1, 0);
        push_beat(1'b1, 8'd0);
        write_timeout(16'hFFFF);
        push_beat(1'b1, 8'd0);
        write_timeout(16'd2);
        push_beat(1'b1, 8'd0);
        write_timeout(16'd3);
        push_beat(1'b1, 8'd0);
    endtask

    // Mostly well-formed frames with random content, plus broken frames,
    // stray bytes and tick bursts, over several timeout settings.
    task automatic test_random_traffic();
        logic [15:0] vals [5];
        logic [7:0]  find;
        int          sent;
        int          pick;
        int          span;
        int          burst;
        frame_kind_t kind;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    write_timeout(16'($urandom_range(0, 20)));
                    idle_odds = 4;
                    span = 30;
                end
                1:
                begin
                    write_timeout(16'($urandom_range(20, 200)));
                    idle_odds = 3;
                    span = 120;
                end
                default:
                begin
                    write_timeout(16'($urandom));
                    idle_odds = 0;
                    span = 20;
                end
            endcase
            sent = 0;
            while (sent < 400)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    for (int k = 0; k < 5; k++)
                        vals[k] = pick_word();
                    find = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                    if (pick < 55)
                        kind = FRAME_GOOD;
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0:       kind = FRAME_BAD_SUM;
                            1:       kind = FRAME_BAD_TAIL;
                            default: kind = FRAME_CUT;
                        endcase
                    end
                    send_frame(kind, find, vals, -1, 8);
                    sent += 14;
                end
                else if (pick < 80)
                begin
                    // Stray bytes, which may include a head that starts a frame.
                    repeat ($urandom_range(1, 4)) push_beat(1'b0, 8'($urandom));
                end
                else
                begin
                    burst = $urandom_range(1, span);
                    repeat (burst) push_beat(1'b1, 8'd0);
                    sent += burst;
                end
            end
        end
    endtask

    initial
    begin
        for (int k = 0; k < PEND_N; k++)
            frame_bytes[k] = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_after_reset();
        test_frame_extremes();
        test_default_timeout();
        test_timeout_edges();
        test_random_traffic();
        drain_results();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
